// ===== hw/rtl/adjacency_stream_to_grid_edges_defines.svh =====
// Assertion macros shared by the RTL of the adjacency stream edge splitter.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ADJACENCY_STREAM_TO_GRID_EDGES_DEFINES_SVH
`define ADJACENCY_STREAM_TO_GRID_EDGES_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define ASGE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication: when ante holds, cons must hold in the same cycle.
`define ASGE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication: when ante holds, cons must hold in the next cycle.
`define ASGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/asge_pkg.sv =====
// Package of the adjacency stream edge splitter: widths, grid constants,
// the parser phase type and the edge record passed from front to back.
// No dependencies.
`default_nettype none

package asge_pkg;

  localparam int unsigned BYTE_W             = 8;
  localparam int unsigned WORD_W             = 48;
  localparam int unsigned FIELD_W            = 24;
  localparam int unsigned WORD_BYTES_DEFAULT = 6;
  localparam int unsigned QUEUE_DEPTH        = 2;

  // Grid width is a power of two, so division is a shift and modulo a mask.
  localparam longint unsigned GRID_WIDTH = 64'd16777216;
  localparam int unsigned     GRID_SHIFT = $clog2(GRID_WIDTH);
  localparam logic [WORD_W-1:0] LOCAL_MASK = (WORD_W'(1) << GRID_SHIFT) - WORD_W'(1);

  typedef enum logic [2:0] {
    PH_SRC = 3'b001,
    PH_CNT = 3'b010,
    PH_NBR = 3'b100
  } phase_e;

  typedef struct packed {
    logic [WORD_W-1:0] big;
    logic [WORD_W-1:0] little;
  } edge_t;

endpackage

`default_nettype wire

// ===== hw/rtl/asge_front.sv =====
// Front end: assembles big-endian words from the byte stream, walks the
// record format and pushes one ordered edge per kept neighbour. Uses asge_pkg.
`default_nettype none

module asge_front
  import asge_pkg::*;
#(
  parameter int unsigned WORD_BYTES = WORD_BYTES_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [BYTE_W-1:0] in_byte_i,
  input  wire logic              queue_ready_i,
  output      logic              push_o,
  output      edge_t             edge_o
);

  localparam int unsigned BIDX_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam logic [BIDX_W-1:0] LAST_IDX = BIDX_W'(WORD_BYTES - 1);

  phase_e              phase_q, phase_d;
  logic [BIDX_W-1:0]   idx_q, idx_d;
  logic [WORD_W-1:0]   accum_q, accum_d;
  logic [WORD_W-1:0]   src_q, src_d;
  logic [WORD_W-1:0]   left_q, left_d;
  logic [WORD_W-1:0]   word;
  logic                accept;
  logic                word_done;

  assign in_ready_o = queue_ready_i;
  assign accept     = in_valid_i && queue_ready_i;
  assign word       = {accum_q[WORD_W-BYTE_W-1:0], in_byte_i};
  assign word_done  = (idx_q == LAST_IDX);

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    accum_d = accum_q;
    src_d   = src_q;
    left_d  = left_q;
    push_o  = 1'b0;
    edge_o.big    = (src_q < word) ? word : src_q;
    edge_o.little = (src_q < word) ? src_q : word;
    if (accept) begin
      if (!word_done) begin
        accum_d = word;
        idx_d   = idx_q + BIDX_W'(1);
      end else begin
        accum_d = '0;
        idx_d   = '0;
        case (phase_q)
          PH_CNT: begin
            if (word == '0) begin
              phase_d = PH_SRC;
            end else begin
              left_d  = word;
              phase_d = PH_NBR;
            end
          end
          PH_NBR: begin
            // A self-loop still uses up one neighbour slot.
            push_o = (src_q != word);
            left_d = left_q - WORD_W'(1);
            if (left_q == WORD_W'(1)) begin
              phase_d = PH_SRC;
            end
          end
          default: begin
            src_d   = word;
            phase_d = PH_CNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SRC;
      idx_q   <= '0;
      accum_q <= '0;
      src_q   <= '0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      accum_q <= accum_d;
      src_q   <= src_d;
      left_q  <= left_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/asge_queue.sv =====
// Two-entry queue of edge records between the parser and the output stage.
// Uses asge_pkg and the assertion macros.
`default_nettype none

`include "adjacency_stream_to_grid_edges_defines.svh"

module asge_queue
  import asge_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire edge_t edge_i,
  output      logic  ready_o,
  input  wire logic  pop_i,
  output      logic  valid_o,
  output      edge_t edge_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  edge_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign edge_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= edge_i;
    end
  end

  `ASGE_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `ASGE_ASSERT_IMPL(a_no_overflow, push_i, ready_o, "push into a full queue")
  `ASGE_ASSERT_IMPL(a_no_underflow, pop_i, valid_o, "pop from an empty queue")
  `ASGE_ASSERT_NEXT(a_cnt_grow, push_i && !pop_i, cnt_q == $past(cnt_q) + CNT_W'(1), "count stuck")

endmodule

`default_nettype wire

// ===== hw/rtl/asge_back.sv =====
// Back end: splits an ordered edge into grid block indices and in-block
// offsets and holds them in the output register. Uses asge_pkg.
`default_nettype none

module asge_back
  import asge_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               queue_valid_i,
  input  wire edge_t              edge_i,
  output      logic               pop_o,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [FIELD_W-1:0] block_row_o,
  output      logic [FIELD_W-1:0] block_col_o,
  output      logic [FIELD_W-1:0] local_row_o,
  output      logic [FIELD_W-1:0] local_col_o
);

  logic               valid_q;
  logic [FIELD_W-1:0] brow_q, bcol_q, lrow_q, lcol_q;
  logic [WORD_W-1:0]  brow_w, bcol_w, lrow_w, lcol_w;

  assign pop_o  = queue_valid_i && (!valid_q || out_ready_i);
  assign brow_w = edge_i.big >> GRID_SHIFT;
  assign bcol_w = edge_i.little >> GRID_SHIFT;
  assign lrow_w = edge_i.big & LOCAL_MASK;
  assign lcol_w = edge_i.little & LOCAL_MASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      brow_q <= brow_w[FIELD_W-1:0];
      bcol_q <= bcol_w[FIELD_W-1:0];
      lrow_q <= lrow_w[FIELD_W-1:0];
      lcol_q <= lcol_w[FIELD_W-1:0];
    end
  end

  assign out_valid_o = valid_q;
  assign block_row_o = brow_q;
  assign block_col_o = bcol_q;
  assign local_row_o = lrow_q;
  assign local_col_o = lcol_q;

endmodule

`default_nettype wire

// ===== hw/rtl/adjacency_stream_to_grid_edges.sv =====
// Top level of the adjacency stream edge splitter: front parser, edge queue
// and output stage. Uses asge_pkg, asge_front, asge_queue and asge_back.
//
//   Channel  Dir  Payload (tdata, lowest bits first)                 Per transfer
//   s_axis   in   in_byte[7:0]                                        one stream byte
//   m_axis   out  block_row, block_col, local_row, local_col (24 each)  one kept edge
//
// One byte is taken per cycle when the edge queue has room; the parser does
// all its work (shift, compare, count down) in the cycle that takes the byte.
// A kept edge is written into the queue at the edge that takes its last byte
// and moves on into the output register once that register is empty or being read
// out; it then waits there while the two-entry queue fills up behind it.
// Reset clears the parser to the start of a record and empties queue and
// output; no clearing pass is needed. s_axis stalls only when the queue is full.
`default_nettype none

module adjacency_stream_to_grid_edges
  import asge_pkg::*;
#(
  parameter int unsigned WORD_BYTES = WORD_BYTES_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output      logic                 s_axis_tready_o,
  // Fields from bit 0 up: in_byte[7:0].
  input  wire logic [BYTE_W-1:0]    s_axis_tdata_i,
  output      logic                 m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // Fields from bit 0 up: block_row[23:0], block_col[47:24],
  // local_row[71:48], local_col[95:72].
  output      logic [4*FIELD_W-1:0] m_axis_tdata_o
);

  logic               queue_ready;
  logic               push;
  edge_t              edge_in;
  logic               queue_valid;
  edge_t              edge_out;
  logic               pop;
  logic [FIELD_W-1:0] block_row, block_col, local_row, local_col;

  // The parser; it stalls the byte stream whenever the queue is full.
  asge_front #(
    .WORD_BYTES (WORD_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_byte_i     (s_axis_tdata_i),
    .queue_ready_i (queue_ready),
    .push_o        (push),
    .edge_o        (edge_in)
  );

  // The queue decouples byte intake from the output handshake.
  asge_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .edge_i  (edge_in),
    .ready_o (queue_ready),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .edge_o  (edge_out)
  );

  // The output stage splits each id into block index and offset.
  asge_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_valid_i (queue_valid),
    .edge_i        (edge_out),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .block_row_o   (block_row),
    .block_col_o   (block_col),
    .local_row_o   (local_row),
    .local_col_o   (local_col)
  );

  assign m_axis_tdata_o = {local_col, local_row, block_col, block_row};

endmodule

`default_nettype wire
